// File: rtl/skt_pkg.sv
// Shared types and constants for the sorted key table.
`timescale 1ns / 1ps
package skt_pkg;

  // Table geometry
  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths
  localparam int MODE_W = 2;
  localparam int KEY_W  = 32;
  localparam int PAY_W  = 16;
  localparam int POS_W  = 6;
  localparam int ECNT_W = 7;

  // Request operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  // What the cell row does at the next edge
  typedef enum logic [1:0] {
    SH_HOLD,
    SH_INSERT,
    SH_DELETE
  } shift_op_t;

  // Controller sequence
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_FINISH
  } ctrl_state_t;

  // Command broadcast to every cell
  typedef struct packed {
    shift_op_t        op;
    logic [IDX_W-1:0] sel;
    logic [CNT_W-1:0] count;
  } cell_cmd_t;

  // Status gathered from the cell row
  typedef struct packed {
    logic             lt_sel;
    logic             eq_sel;
    logic [PAY_W-1:0] pay_sel;
    logic [IDX_W-1:0] ins_pos;
  } row_stat_t;

endpackage

// File: rtl/skt_req_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface skt_req_if
  import skt_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic signed [KEY_W-1:0] key;
  logic [PAY_W-1:0]        payload;

  modport source (output valid, output mode, output key, output payload, input ready);
  modport sink   (input valid, input mode, input key, input payload, output ready);
endinterface

interface skt_rsp_if
  import skt_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              success;
  logic [POS_W-1:0]  position;
  logic [PAY_W-1:0]  found_payload;
  logic [ECNT_W-1:0] entry_count;

  modport source (output valid, output success, output position, output found_payload,
                  output entry_count, input ready);
  modport sink   (input valid, input success, input position, input found_payload,
                  input entry_count, output ready);
endinterface

// File: rtl/skt_cell.sv
// One table slot: holds a record, compares it with the request key, shifts with neighbors.
`timescale 1ns / 1ps
module skt_cell
  import skt_pkg::*;
(
  input  logic                    clk,
  input  logic [IDX_W-1:0]        idx,
  input  cell_cmd_t               cmd,
  input  logic signed [KEY_W-1:0] req_key,
  input  logic [PAY_W-1:0]        req_pay,
  input  logic signed [KEY_W-1:0] left_key,
  input  logic [PAY_W-1:0]        left_pay,
  input  logic                    left_gt,
  input  logic                    left_ok,
  input  logic signed [KEY_W-1:0] right_key,
  input  logic [PAY_W-1:0]        right_pay,
  output logic signed [KEY_W-1:0] cell_key,
  output logic [PAY_W-1:0]        cell_pay,
  output logic                    cell_gt,
  output logic                    cell_ok,
  output logic                    lt_sel,
  output logic                    eq_sel,
  output logic [PAY_W-1:0]        pay_sel,
  output logic                    take_new
);

  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [PAY_W-1:0]        pay_r, pay_nxt;
  logic                    occupied;
  logic                    picked;

  // Slot is live when its index is below the count
  assign occupied = (CNT_W'(idx) < cmd.count);
  assign picked   = (idx == cmd.sel);

  assign cell_gt  = occupied && (key_r > req_key);
  assign cell_ok  = occupied && !(key_r > req_key);
  assign take_new = left_ok && !cell_gt ? !occupied : left_ok && cell_gt;

  // Flags and payload of the slot the controller points at
  assign lt_sel  = picked && (key_r < req_key);
  assign eq_sel  = picked && (key_r == req_key);
  assign pay_sel = picked ? pay_r : '0;

  assign cell_key = key_r;
  assign cell_pay = pay_r;

  // Next contents: keep the record, or take the new record, the left neighbor, or the right neighbor
  always_comb begin
    key_nxt = key_r;
    pay_nxt = pay_r;
    case (cmd.op)
      SH_INSERT: begin
        if (left_gt) begin
          key_nxt = left_key;
          pay_nxt = left_pay;
        end else if (take_new) begin
          key_nxt = req_key;
          pay_nxt = req_pay;
        end
      end
      SH_DELETE: begin
        if (idx >= cmd.sel) begin
          key_nxt = right_key;
          pay_nxt = right_pay;
        end
      end
      default: begin
        key_nxt = key_r;
        pay_nxt = pay_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    pay_r <= pay_nxt;
  end

endmodule

// File: rtl/skt_ctrl.sv
// Sequencer: takes requests, runs the binary search, keeps the count, holds the result.
`timescale 1ns / 1ps
module skt_ctrl
  import skt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  skt_req_if.sink                 in_ch,
  skt_rsp_if.source               out_ch,
  input  row_stat_t               stat,
  output cell_cmd_t               cmd,
  output logic signed [KEY_W-1:0] req_key,
  output logic [PAY_W-1:0]        req_pay
);

  ctrl_state_t             state_r, state_nxt;
  mode_t                   mode_r, mode_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [PAY_W-1:0]        pay_r, pay_nxt;
  logic [CNT_W-1:0]        lo_r, lo_nxt;
  logic [CNT_W-1:0]        hiex_r, hiex_nxt;   // one past the upper search bound
  logic [IDX_W-1:0]        hit_r, hit_nxt;
  logic                    found_r, found_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    success_r, success_nxt;
  logic [POS_W-1:0]        position_r, position_nxt;
  logic [PAY_W-1:0]        fpay_r, fpay_nxt;
  logic [ECNT_W-1:0]       ecount_r, ecount_nxt;

  logic                    in_ready;
  logic                    out_free;
  logic                    load;
  logic [CNT_W:0]          mid_sum;
  logic [IDX_W-1:0]        mid;

  // Floor midpoint of lo and hi, with hi = hiex - 1
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hiex_r} - (CNT_W + 1)'(1);
  assign mid      = IDX_W'(mid_sum >> 1);
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready = in_ready;
  assign req_key     = key_r;
  assign req_pay     = pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    key_r      <= key_nxt;
    pay_r      <= pay_nxt;
    lo_r       <= lo_nxt;
    hiex_r     <= hiex_nxt;
    hit_r      <= hit_nxt;
    found_r    <= found_nxt;
    success_r  <= success_nxt;
    position_r <= position_nxt;
    fpay_r     <= fpay_nxt;
    ecount_r   <= ecount_nxt;
  end

  // Next state, row command and result
  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    key_nxt      = key_r;
    pay_nxt      = pay_r;
    lo_nxt       = lo_r;
    hiex_nxt     = hiex_r;
    hit_nxt      = hit_r;
    found_nxt    = found_r;
    count_nxt    = count_r;
    success_nxt  = success_r;
    position_nxt = position_r;
    fpay_nxt     = fpay_r;
    ecount_nxt   = ecount_r;
    in_ready     = 1'b0;
    load         = 1'b0;
    cmd.op       = SH_HOLD;
    cmd.sel      = mid;
    cmd.count    = count_r;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          mode_nxt  = mode_t'(in_ch.mode);
          key_nxt   = in_ch.key;
          pay_nxt   = in_ch.payload;
          lo_nxt    = '0;
          hiex_nxt  = count_r;
          found_nxt = 1'b0;
          state_nxt = ST_WORK;
        end
      end

      ST_WORK: begin
        case (mode_r)
          MODE_INSERT: begin
            if (out_free) begin
              load         = 1'b1;
              fpay_nxt     = '0;
              if (count_r != CNT_W'(CAPACITY)) begin
                cmd.op       = SH_INSERT;
                count_nxt    = count_r + CNT_W'(1);
                success_nxt  = 1'b1;
                position_nxt = POS_W'(stat.ins_pos);
              end else begin
                success_nxt  = 1'b0;
                position_nxt = '0;
              end
              ecount_nxt = ECNT_W'(count_nxt);
              state_nxt  = ST_IDLE;
            end
          end
          MODE_CLEAR: begin
            if (out_free) begin
              load         = 1'b1;
              count_nxt    = '0;
              success_nxt  = 1'b1;
              position_nxt = '0;
              fpay_nxt     = '0;
              ecount_nxt   = '0;
              state_nxt    = ST_IDLE;
            end
          end
          MODE_DELETE, MODE_LOOKUP: begin
            // One probe per cycle at the midpoint
            if (lo_r < hiex_r) begin
              if (stat.eq_sel) begin
                hit_nxt   = mid;
                found_nxt = 1'b1;
                state_nxt = ST_FINISH;
              end else if (stat.lt_sel) begin
                lo_nxt = CNT_W'(mid) + CNT_W'(1);
              end else begin
                hiex_nxt = CNT_W'(mid);
              end
            end else begin
              state_nxt = ST_FINISH;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end

      ST_FINISH: begin
        cmd.sel = hit_r;
        if (out_free) begin
          load         = 1'b1;
          success_nxt  = found_r;
          position_nxt = found_r ? POS_W'(hit_r) : '0;
          fpay_nxt     = (found_r && mode_r == MODE_LOOKUP) ? stat.pay_sel : '0;
          if (found_r && mode_r == MODE_DELETE) begin
            cmd.op    = SH_DELETE;
            count_nxt = count_r - CNT_W'(1);
          end
          ecount_nxt = ECNT_W'(count_nxt);
          state_nxt  = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // Output register: filled on load, emptied when taken
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.success       = success_r;
  assign out_ch.position      = position_r;
  assign out_ch.found_payload = fpay_r;
  assign out_ch.entry_count   = ecount_r;

endmodule

// File: rtl/sorted_key_table.sv
// Top level: sorted key table built from a chain of record cells and a sequencer.
//
//  channel  dir  handshake      payload
//  in_ch    in   valid / ready  mode, key, payload
//  out_ch   out  valid / ready  success, position, found_payload, entry_count
//
// Insert and clear go from request to result through the work state; every cell compares at once and
// the whole row shifts together. Delete and lookup run a binary search, one probe per cycle
// at the midpoint cell, then, on a miss, a check that sees an empty range, then a finish
// step.
// One request is in work at a time; a new one is taken while the last result waits.
// Reset (rst_n low, synchronous) empties the table; record contents are not cleared.
// A stalled out_ch holds the result and the sequencer waits before changing the table.
`timescale 1ns / 1ps
module sorted_key_table
  import skt_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  skt_req_if.sink   in_ch,
  skt_rsp_if.source out_ch
);

  cell_cmd_t               cmd;
  row_stat_t               stat;
  logic signed [KEY_W-1:0] req_key;
  logic [PAY_W-1:0]        req_pay;

  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic [PAY_W-1:0]        cell_pay [CAPACITY];
  logic                    cell_gt  [CAPACITY];
  logic                    cell_ok  [CAPACITY];
  logic                    lt_sel   [CAPACITY];
  logic                    eq_sel   [CAPACITY];
  logic [PAY_W-1:0]        pay_sel  [CAPACITY];
  logic                    take_new [CAPACITY];

  skt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .stat    (stat),
    .cmd     (cmd),
    .req_key (req_key),
    .req_pay (req_pay)
  );

  // Cell chain; the first cell sees a fixed left neighbor, the last cell is its own right neighbor
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [KEY_W-1:0] l_key;
    logic [PAY_W-1:0]        l_pay;
    logic                    l_gt;
    logic                    l_ok;
    logic signed [KEY_W-1:0] r_key;
    logic [PAY_W-1:0]        r_pay;

    if (g == 0) begin : g_first
      assign l_key = '0;
      assign l_pay = '0;
      assign l_gt  = 1'b0;
      assign l_ok  = 1'b1;
    end else begin : g_mid
      assign l_key = cell_key[g-1];
      assign l_pay = cell_pay[g-1];
      assign l_gt  = cell_gt[g-1];
      assign l_ok  = cell_ok[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign r_key = cell_key[g];
      assign r_pay = cell_pay[g];
    end else begin : g_inner
      assign r_key = cell_key[g+1];
      assign r_pay = cell_pay[g+1];
    end

    skt_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(g)),
      .cmd       (cmd),
      .req_key   (req_key),
      .req_pay   (req_pay),
      .left_key  (l_key),
      .left_pay  (l_pay),
      .left_gt   (l_gt),
      .left_ok   (l_ok),
      .right_key (r_key),
      .right_pay (r_pay),
      .cell_key  (cell_key[g]),
      .cell_pay  (cell_pay[g]),
      .cell_gt   (cell_gt[g]),
      .cell_ok   (cell_ok[g]),
      .lt_sel    (lt_sel[g]),
      .eq_sel    (eq_sel[g]),
      .pay_sel   (pay_sel[g]),
      .take_new  (take_new[g])
    );
  end

  // Gather the selected cell's flags and payload, and the insert slot index
  always_comb begin
    stat = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      stat.lt_sel  = stat.lt_sel | lt_sel[i];
      stat.eq_sel  = stat.eq_sel | eq_sel[i];
      stat.pay_sel = stat.pay_sel | pay_sel[i];
      if (take_new[i]) begin
        stat.ins_pos = stat.ins_pos | IDX_W'(i);
      end
    end
  end

endmodule
